// ===== src/fnp_pkg.sv =====
// shared types, constants and the nucleotide code table for the fasta parser
// no dependencies
package fnp_pkg;

   localparam int unsigned MAX_RECORDS     = 4096;
   localparam int unsigned MAX_SEQ_LENGTH  = 1048576;
   localparam int unsigned MAX_NAME_LENGTH = 1024;

   localparam logic [7:0] CHAR_GT    = 8'h3E;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef enum logic [1:0] {
      MODE_BEFORE = 2'd0,
      MODE_NAME   = 2'd1,
      MODE_SEQ    = 2'd2,
      MODE_DONE   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      KIND_SKIP   = 3'd0,
      KIND_NAME   = 3'd1,
      KIND_BASE   = 3'd2,
      KIND_START  = 3'd3,
      KIND_OK     = 3'd4,
      KIND_ERROR  = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_TOO_MANY = 3'd1,
      ERR_LENGTH   = 3'd2,
      ERR_INVALID  = 3'd3,
      ERR_COUNT    = 3'd4,
      ERR_SIZE     = 3'd5
   } err_type;

   // classified word handed from front to back
   typedef struct packed {
      logic       eof;
      logic       is_gt;
      logic       is_crlf;
      logic       is_ws;
      logic [7:0] data;
      logic [7:0] code;
   } fnp_entry_type;

   function automatic logic [7:0] nuc_code(input logic [7:0] ch);
      logic [7:0] code;
      case (ch)
         8'h2D:        code = 8'h04;
         8'h3F:        code = 8'h02;
         8'h41, 8'h61: code = 8'h88;
         8'h47, 8'h67: code = 8'h48;
         8'h43, 8'h63: code = 8'h28;
         8'h54, 8'h74: code = 8'h18;
         8'h52, 8'h72: code = 8'hC0;
         8'h4D, 8'h6D: code = 8'hA0;
         8'h57, 8'h77: code = 8'h90;
         8'h53, 8'h73: code = 8'h60;
         8'h4B, 8'h6B: code = 8'h50;
         8'h59, 8'h79: code = 8'h30;
         8'h56, 8'h76: code = 8'hE0;
         8'h48, 8'h68: code = 8'hB0;
         8'h44, 8'h64: code = 8'hD0;
         8'h42, 8'h62: code = 8'h70;
         8'h4E, 8'h6E: code = 8'hF0;
         default:      code = 8'h00;
      endcase
      return code;
   endfunction

endpackage

// ===== src/fnp_front.sv =====
// front end: input handshake and byte classification with code lookup
// depends on fnp_pkg
module fnp_front
   import fnp_pkg::*;
(
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_operation,
   input  logic [7:0]    req_data_byte,
   input  logic          q_full,
   output logic          q_push,
   output fnp_entry_type q_entry
);

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_entry.eof     = req_operation;
      q_entry.data    = req_data_byte;
      q_entry.code    = nuc_code(req_data_byte);
      q_entry.is_gt   = (req_data_byte == CHAR_GT);
      q_entry.is_crlf = (req_data_byte == CHAR_CR) || (req_data_byte == CHAR_LF);
      q_entry.is_ws   = (req_data_byte == CHAR_TAB) || (req_data_byte == CHAR_SPACE);
   end

endmodule

// ===== src/fnp_queue.sv =====
// two-word queue between front and back
// depends on fnp_pkg
module fnp_queue
   import fnp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  fnp_entry_type push_entry,
   output logic          full,
   input  logic          pop,
   output logic          empty,
   output fnp_entry_type head
);

   fnp_entry_type slot_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("queue pop while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2) else $error("queue count out of range");
`endif

endmodule

// ===== src/fnp_back.sv =====
// back end: parse state, error tracking, configuration register and result register
// depends on fnp_pkg
module fnp_back
   import fnp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic [12:0]   csr_wr_data,
   input  logic          q_empty,
   input  fnp_entry_type q_head,
   output logic          q_pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [2:0]    rsp_kind,
   output logic [7:0]    rsp_value,
   output logic [11:0]   rsp_record_index,
   output logic [19:0]   rsp_position,
   output logic [31:0]   rsp_address,
   output logic [2:0]    rsp_error_code,
   output logic [31:0]   rsp_known_count
);

   logic [12:0] exp_seq_ff;
   mode_type    mode_ff, mode_in;
   logic [12:0] rec_cnt_ff, rec_cnt_in;
   logic [10:0] name_len_ff, name_len_in;
   logic [20:0] base_pos_ff, base_pos_in;
   logic [20:0] first_len_ff, first_len_in;
   logic        first_known_ff, first_known_in;
   logic [31:0] rec_base_ff, rec_base_in;
   logic [31:0] known_ff, known_in;
   err_type     sticky_ff, sticky_in;

   logic        valid_ff;
   kind_type    kind_ff, kind_in;
   logic [7:0]  value_ff, value_in;
   logic [11:0] index_ff, index_in;
   logic [19:0] pos_ff, pos_in;
   logic [31:0] addr_ff, addr_in;
   err_type     err_ff, err_in;
   logic [31:0] count_ff;

   logic        close_err;
   logic [20:0] close_len;
   logic [20:0] gt_len;
   logic        gt_known;
   logic [13:0] rec_inc;
   logic [12:0] idx_wide;
   err_type     err;

   assign q_pop = !q_empty && (!valid_ff || rsp_ready);

   always_comb begin
      mode_in        = mode_ff;
      rec_cnt_in     = rec_cnt_ff;
      name_len_in    = name_len_ff;
      base_pos_in    = base_pos_ff;
      first_len_in   = first_len_ff;
      first_known_in = first_known_ff;
      rec_base_in    = rec_base_ff;
      known_in       = known_ff;
      sticky_in      = sticky_ff;
      kind_in        = KIND_SKIP;
      value_in       = 8'd0;
      pos_in         = 20'd0;
      addr_in        = 32'd0;
      err_in         = ERR_NONE;
      err            = ERR_NONE;

      close_err = first_known_ff && (base_pos_ff != first_len_ff);
      close_len = first_known_ff ? first_len_ff : base_pos_ff;
      gt_len    = (mode_ff == MODE_SEQ) ? close_len : first_len_ff;
      gt_known  = (mode_ff == MODE_SEQ) ? 1'b1 : first_known_ff;
      rec_inc   = {1'b0, rec_cnt_ff} + 14'd1;

      if (sticky_ff != ERR_NONE) begin
         kind_in = KIND_ERROR;
         err_in  = sticky_ff;
      end else if (mode_ff == MODE_DONE) begin
         kind_in = KIND_OK;
      end else if (q_head.eof) begin
         if (mode_ff != MODE_BEFORE && close_err) begin
            err = ERR_LENGTH;
         end else if (rec_cnt_ff != exp_seq_ff) begin
            err = ERR_COUNT;
         end
         if (mode_ff != MODE_BEFORE) begin
            first_len_in   = close_len;
            first_known_in = 1'b1;
         end
         if (err != ERR_NONE) begin
            sticky_in = err;
            kind_in   = KIND_ERROR;
            err_in    = err;
         end else begin
            mode_in = MODE_DONE;
            kind_in = KIND_OK;
         end
      end else if (mode_ff == MODE_NAME) begin
         if (q_head.is_crlf) begin
            mode_in = MODE_SEQ;
         end else if (name_len_ff >= 11'(MAX_NAME_LENGTH)) begin
            sticky_in = ERR_SIZE;
            kind_in   = KIND_ERROR;
            err_in    = ERR_SIZE;
         end else begin
            kind_in     = KIND_NAME;
            value_in    = q_head.data;
            pos_in      = 20'(name_len_ff);
            name_len_in = name_len_ff + 11'd1;
         end
      end else if (q_head.is_gt) begin
         if (mode_ff == MODE_SEQ && close_err) begin
            err = ERR_LENGTH;
         end else if (rec_inc > {1'b0, exp_seq_ff}) begin
            err = ERR_TOO_MANY;
         end else if (rec_inc > 14'(MAX_RECORDS)) begin
            err = ERR_SIZE;
         end
         first_len_in   = gt_len;
         first_known_in = gt_known;
         if (err != ERR_NONE) begin
            sticky_in = err;
            kind_in   = KIND_ERROR;
            err_in    = err;
         end else begin
            if (rec_cnt_ff != 13'd0) begin
               rec_base_in = rec_base_ff + 32'(gt_len);
            end
            rec_cnt_in  = rec_inc[12:0];
            name_len_in = 11'd0;
            base_pos_in = 21'd0;
            mode_in     = MODE_NAME;
            kind_in     = KIND_START;
            addr_in     = rec_base_in;
         end
      end else if (mode_ff == MODE_BEFORE || q_head.is_crlf || q_head.is_ws) begin
         kind_in = KIND_SKIP;
      end else begin
         if (q_head.code == 8'd0) begin
            err = ERR_INVALID;
         end else if (first_known_ff && base_pos_ff >= first_len_ff) begin
            err = ERR_LENGTH;
         end else if (base_pos_ff >= 21'(MAX_SEQ_LENGTH)) begin
            err = ERR_SIZE;
         end
         if (err != ERR_NONE) begin
            sticky_in = err;
            kind_in   = KIND_ERROR;
            err_in    = err;
         end else begin
            if (q_head.code[3] && known_ff != 32'hFFFF_FFFF) begin
               known_in = known_ff + 32'd1;
            end
            kind_in     = KIND_BASE;
            value_in    = q_head.code;
            pos_in      = base_pos_ff[19:0];
            addr_in     = rec_base_ff + 32'(base_pos_ff);
            base_pos_in = base_pos_ff + 21'd1;
         end
      end

      idx_wide = (rec_cnt_in != 13'd0) ? rec_cnt_in - 13'd1 : 13'd0;
      index_in = idx_wide[11:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_seq_ff     <= 13'd1;
         mode_ff        <= MODE_BEFORE;
         rec_cnt_ff     <= 13'd0;
         name_len_ff    <= 11'd0;
         base_pos_ff    <= 21'd0;
         first_len_ff   <= 21'd0;
         first_known_ff <= 1'b0;
         rec_base_ff    <= 32'd0;
         known_ff       <= 32'd0;
         sticky_ff      <= ERR_NONE;
         valid_ff       <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            exp_seq_ff <= csr_wr_data;
         end
         if (q_pop) begin
            mode_ff        <= mode_in;
            rec_cnt_ff     <= rec_cnt_in;
            name_len_ff    <= name_len_in;
            base_pos_ff    <= base_pos_in;
            first_len_ff   <= first_len_in;
            first_known_ff <= first_known_in;
            rec_base_ff    <= rec_base_in;
            known_ff       <= known_in;
            sticky_ff      <= sticky_in;
            valid_ff       <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         kind_ff  <= kind_in;
         value_ff <= value_in;
         index_ff <= index_in;
         pos_ff   <= pos_in;
         addr_ff  <= addr_in;
         err_ff   <= err_in;
         count_ff <= known_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_value        = value_ff;
   assign rsp_record_index = index_ff;
   assign rsp_position     = pos_ff;
   assign rsp_address      = addr_ff;
   assign rsp_error_code   = err_ff;
   assign rsp_known_count  = count_ff;

`ifndef SYNTH
   a_sticky_holds: assert property (@(posedge clock) disable iff (reset)
      sticky_ff != ERR_NONE |=> sticky_ff == $past(sticky_ff))
      else $error("sticky error changed");
   a_err_only_on_error: assert property (@(posedge clock) disable iff (reset)
      valid_ff && kind_ff != KIND_ERROR |-> err_ff == ERR_NONE)
      else $error("error code on non-error word");
   a_error_has_code: assert property (@(posedge clock) disable iff (reset)
      valid_ff && kind_ff == KIND_ERROR |-> err_ff != ERR_NONE)
      else $error("error word without code");
   a_done_after_ok: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_DONE |=> mode_ff == MODE_DONE)
      else $error("left done mode");
`endif

endmodule

// ===== src/fasta_to_nucleotide_code_parser.sv =====
// top level of the fasta parser: front end, two-word queue, back end
// depends on fnp_pkg, fnp_front, fnp_queue, fnp_back
//
// Takes one FASTA byte (or an end-of-file word) per cycle while the queue has room and
// returns one result word per input word, in order, at one word per clock while the output
// is not stalled. A word leaves the front end the cycle it is accepted, is written into a
// two-word queue, and the back end turns it into a result through the code table lookup and
// the counter and address adders, held in the result register. The two-word queue lets
// the next word be accepted while a result waits to be taken. expected_sequences may be
// written only while the block is idle.
module fasta_to_nucleotide_code_parser
   import fnp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [12:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_value,
   output logic [11:0] rsp_record_index,
   output logic [19:0] rsp_position,
   output logic [31:0] rsp_address,
   output logic [2:0]  rsp_error_code,
   output logic [31:0] rsp_known_count
);

   logic          q_full;
   logic          q_push;
   logic          q_pop;
   logic          q_empty;
   fnp_entry_type q_entry;
   fnp_entry_type q_head;

   fnp_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_data_byte (req_data_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_entry       (q_entry)
   );

   fnp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head       (q_head)
   );

   fnp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .q_empty          (q_empty),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_value        (rsp_value),
      .rsp_record_index (rsp_record_index),
      .rsp_position     (rsp_position),
      .rsp_address      (rsp_address),
      .rsp_error_code   (rsp_error_code),
      .rsp_known_count  (rsp_known_count)
   );

endmodule

// ===== tb/tb_fasta_to_nucleotide_code_parser.sv =====
// self-checking testbench for fasta_to_nucleotide_code_parser
// drives FASTA byte words and checks every result word against a cycle-free
// parser model; depends on fnp_pkg and the parser top level only
`timescale 1ns / 1ps

module tb_fasta_to_nucleotide_code_parser;
   import fnp_pkg::*;

   localparam int CLOCK_PERIOD = 10;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PRINT_LIMIT  = 50;
   localparam logic OP_TEXT = 1'b0;
   localparam logic OP_EOF  = 1'b1;
   localparam logic [12:0] RECORDS_MIN = 13'd1;
   localparam logic [12:0] RECORDS_MAX = 13'd4096;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  value;
      logic [11:0] rec_index;
      logic [19:0] pos;
      logic [31:0] addr;
      err_type     err;
      logic [31:0] known;
   } parse_result_type;

   typedef enum int {
      END_OK, END_COUNT, END_TOO_MANY, END_SHORT, END_LONG, END_INVALID,
      END_NAME_SIZE, END_EOF_IN_NAME
   } ending_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [12:0] csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_operation = 1'b0;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_value;
   logic [11:0] rsp_record_index;
   logic [19:0] rsp_position;
   logic [31:0] rsp_address;
   logic [2:0]  rsp_error_code;
   logic [31:0] rsp_known_count;

   // parser model state
   mode_type    cur_mode = MODE_BEFORE;
   logic [12:0] expected_records = RECORDS_MIN;
   logic [12:0] records_open = '0;
   logic [10:0] name_chars = '0;
   logic [20:0] seq_pos = '0;
   logic [20:0] ref_length = '0;
   logic        ref_length_set = 1'b0;
   logic [31:0] seq_base = '0;
   logic [31:0] known_bases = '0;
   err_type     latched_error = ERR_NONE;

   parse_result_type pending_results[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int words_sent = 0;
   int words_checked = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int seq_len = 8;
   int record_words = 240;
   ending_type ending = END_OK;
   string base_chars = "ACGTRMWSKYVHDBNacgtrmwskyvhdbn-?";

   fasta_to_nucleotide_code_parser i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_value        (rsp_value),
      .rsp_record_index (rsp_record_index),
      .rsp_position     (rsp_position),
      .rsp_address      (rsp_address),
      .rsp_error_code   (rsp_error_code),
      .rsp_known_count  (rsp_known_count)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words pending", cycle_count,
                  pending_results.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic logic [7:0] base_code(input logic [7:0] ch);
      logic [7:0] up;
      up = (ch >= "a" && ch <= "z") ? (ch & 8'hDF) : ch;
      case (up)
         "A":     return 8'h88;
         "G":     return 8'h48;
         "C":     return 8'h28;
         "T":     return 8'h18;
         "R":     return 8'hC0;
         "M":     return 8'hA0;
         "W":     return 8'h90;
         "S":     return 8'h60;
         "K":     return 8'h50;
         "Y":     return 8'h30;
         "V":     return 8'hE0;
         "H":     return 8'hB0;
         "D":     return 8'hD0;
         "B":     return 8'h70;
         "N":     return 8'hF0;
         "-":     return 8'h04;
         "?":     return 8'h02;
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic is_blank(input logic [7:0] ch);
      return ch == CHAR_CR || ch == CHAR_LF || ch == CHAR_TAB || ch == CHAR_SPACE;
   endfunction

   function automatic parse_result_type make_result(input kind_type k, input logic [7:0] v,
                                                    input logic [19:0] p,
                                                    input logic [31:0] a,
                                                    input err_type e);
      parse_result_type r;
      r.kind      = k;
      r.value     = v;
      r.rec_index = (records_open != 0) ? 12'(records_open - 13'd1) : 12'd0;
      r.pos       = p;
      r.addr      = a;
      r.err       = e;
      r.known     = known_bases;
      return r;
   endfunction

   function automatic err_type check_record_length();
      if (!ref_length_set) begin
         ref_length     = seq_pos;
         ref_length_set = 1'b1;
         return ERR_NONE;
      end
      return (seq_pos != ref_length) ? ERR_LENGTH : ERR_NONE;
   endfunction

   function automatic parse_result_type translate_word(input logic op, input logic [7:0] b);
      err_type e;
      logic [7:0] code;
      parse_result_type r;
      e = ERR_NONE;
      if (latched_error != ERR_NONE)
         return make_result(KIND_ERROR, 8'd0, 20'd0, 32'd0, latched_error);
      if (cur_mode == MODE_DONE)
         return make_result(KIND_OK, 8'd0, 20'd0, 32'd0, ERR_NONE);
      if (op == OP_EOF) begin
         if (cur_mode != MODE_BEFORE)
            e = check_record_length();
         if (e == ERR_NONE && records_open != expected_records)
            e = ERR_COUNT;
         if (e != ERR_NONE) begin
            latched_error = e;
            return make_result(KIND_ERROR, 8'd0, 20'd0, 32'd0, e);
         end
         cur_mode = MODE_DONE;
         return make_result(KIND_OK, 8'd0, 20'd0, 32'd0, ERR_NONE);
      end
      if (cur_mode == MODE_NAME) begin
         if (b == CHAR_CR || b == CHAR_LF) begin
            cur_mode = MODE_SEQ;
            return make_result(KIND_SKIP, 8'd0, 20'd0, 32'd0, ERR_NONE);
         end
         if (name_chars >= MAX_NAME_LENGTH) begin
            latched_error = ERR_SIZE;
            return make_result(KIND_ERROR, 8'd0, 20'd0, 32'd0, ERR_SIZE);
         end
         r = make_result(KIND_NAME, b, 20'(name_chars), 32'd0, ERR_NONE);
         name_chars++;
         return r;
      end
      if (b == CHAR_GT) begin
         if (cur_mode == MODE_SEQ)
            e = check_record_length();
         if (e == ERR_NONE && int'(records_open) + 1 > int'(expected_records))
            e = ERR_TOO_MANY;
         if (e == ERR_NONE && int'(records_open) + 1 > MAX_RECORDS)
            e = ERR_SIZE;
         if (e != ERR_NONE) begin
            latched_error = e;
            return make_result(KIND_ERROR, 8'd0, 20'd0, 32'd0, e);
         end
         if (records_open != 0)
            seq_base += 32'(ref_length);
         records_open++;
         name_chars = '0;
         seq_pos    = '0;
         cur_mode   = MODE_NAME;
         return make_result(KIND_START, 8'd0, 20'd0, seq_base, ERR_NONE);
      end
      if (cur_mode == MODE_BEFORE || is_blank(b))
         return make_result(KIND_SKIP, 8'd0, 20'd0, 32'd0, ERR_NONE);
      code = base_code(b);
      if (code == 8'd0)
         e = ERR_INVALID;
      else if (ref_length_set && seq_pos >= ref_length)
         e = ERR_LENGTH;
      else if (seq_pos >= MAX_SEQ_LENGTH)
         e = ERR_SIZE;
      if (e != ERR_NONE) begin
         latched_error = e;
         return make_result(KIND_ERROR, 8'd0, 20'd0, 32'd0, e);
      end
      if (code[3] && known_bases != '1)
         known_bases++;
      r = make_result(KIND_BASE, code, seq_pos[19:0], seq_base + 32'(seq_pos), ERR_NONE);
      seq_pos++;
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < PRINT_LIMIT)
         $display("mismatch on result word %0d: %s got 0x%0h expected 0x%0h",
                  words_checked, field, got, want);
      mismatch_count++;
   endtask

   task automatic check_result(input parse_result_type want);
      if (rsp_kind !== want.kind)
         report_mismatch("kind", rsp_kind, want.kind);
      if (rsp_value !== want.value)
         report_mismatch("value", rsp_value, want.value);
      if (rsp_record_index !== want.rec_index)
         report_mismatch("record_index", rsp_record_index, want.rec_index);
      if (rsp_position !== want.pos)
         report_mismatch("position", rsp_position, want.pos);
      if (rsp_address !== want.addr)
         report_mismatch("address", rsp_address, want.addr);
      if (rsp_error_code !== want.err)
         report_mismatch("error_code", rsp_error_code, want.err);
      if (rsp_known_count !== want.known)
         report_mismatch("known_count", rsp_known_count, want.known);
   endtask

   // result words are retired before the word accepted at the same edge is predicted
   always @(posedge clock) begin : monitor
      parse_result_type want;
      if (!reset) begin
         if (csr_wr_en)
            expected_records = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected result, kind", rsp_kind, 32'd0);
            end else begin
               want = pending_results.pop_front();
               check_result(want);
            end
            words_checked++;
         end
         if (req_valid && req_ready)
            pending_results.push_back(translate_word(req_operation, req_data_byte));
      end
   end

   task automatic send_word(input logic op, input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      words_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (words_checked < words_sent)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_expected(input logic [12:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [7:0] random_name_byte();
      logic [7:0] b;
      do
         b = $urandom_range(255);
      while (b == CHAR_CR || b == CHAR_LF);
      return b;
   endfunction

   function automatic logic [7:0] blank_byte();
      case ($urandom_range(3))
         0:       return CHAR_TAB;
         1:       return CHAR_SPACE;
         2:       return CHAR_CR;
         default: return CHAR_LF;
      endcase
   endfunction

   task automatic send_record(input int name_len, input int bases);
      send_word(OP_TEXT, CHAR_GT);
      for (int i = 0; i < name_len; i++)
         send_word(OP_TEXT, random_name_byte());
      case ($urandom_range(3))
         0, 1: begin
            send_word(OP_TEXT, CHAR_CR);
            send_word(OP_TEXT, CHAR_LF);
         end
         2: send_word(OP_TEXT, CHAR_LF);
         default: send_word(OP_TEXT, CHAR_CR);
      endcase
      for (int i = 0; i < bases; i++) begin
         if ($urandom_range(99) < 15)
            send_word(OP_TEXT, blank_byte());
         send_word(OP_TEXT, base_chars[$urandom_range(31)]);
      end
   endtask

   // bytes ahead of the first header are all skipped
   task automatic test_preamble();
      send_idle_pct = 36;
      recv_idle_pct = 65;
      write_expected(RECORDS_MIN);
      send_word(OP_TEXT, 8'h00);
      send_word(OP_TEXT, 8'hFF);
      send_word(OP_TEXT, "A");
      send_word(OP_TEXT, CHAR_CR);
      send_word(OP_TEXT, CHAR_LF);
      send_word(OP_TEXT, CHAR_TAB);
      send_word(OP_TEXT, CHAR_SPACE);
      send_word(OP_TEXT, "<");
   endtask

   // first record fixes the sequence length; '>' inside a name is a name byte
   task automatic test_first_record();
      int offset;
      seq_len = $urandom_range(12, 8);
      offset  = $urandom_range(31);
      send_word(OP_TEXT, CHAR_GT);
      send_word(OP_TEXT, CHAR_GT);
      send_word(OP_TEXT, 8'h00);
      send_word(OP_TEXT, 8'hFF);
      send_word(OP_TEXT, 8'h55);
      send_word(OP_TEXT, 8'hAA);
      send_word(OP_TEXT, CHAR_CR);
      send_word(OP_TEXT, CHAR_LF);
      for (int i = 0; i < seq_len; i++) begin
         if (i == 2)
            send_word(OP_TEXT, CHAR_TAB);
         if (i == 5)
            send_word(OP_TEXT, CHAR_SPACE);
         send_word(OP_TEXT, base_chars[(offset + i) % 32]);
      end
      wait_idle();
      write_expected(RECORDS_MAX);
   endtask

   task automatic test_random_records(input int send_pct, input int recv_pct,
                                      input int words);
      int stop_at;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      write_expected(13'(int'(records_open) +
                         $urandom_range(int'(RECORDS_MAX) - int'(records_open), 40)));
      stop_at = words_sent + words;
      while (words_sent < stop_at) begin
         if ($urandom_range(99) < 80)
            send_record($urandom_range(6), seq_len);
         else
            send_record($urandom_range(40, 7), seq_len);
      end
      wait_idle();
   endtask

   // one terminal case per run: a clean end of file or one of the sticky errors
   task automatic test_termination();
      logic [7:0] b;
      case (ending)
         END_OK: begin
            write_expected(records_open);
            send_word(OP_EOF, $urandom_range(255));
         end
         END_COUNT: begin
            write_expected(13'(records_open + $urandom_range(5, 1)));
            send_word(OP_EOF, $urandom_range(255));
         end
         END_TOO_MANY: begin
            write_expected(records_open);
            send_word(OP_TEXT, CHAR_GT);
         end
         END_SHORT: begin
            send_record(3, $urandom_range(seq_len - 1));
            if ($urandom_range(1))
               send_word(OP_TEXT, CHAR_GT);
            else
               send_word(OP_EOF, $urandom_range(255));
         end
         END_LONG: send_record(2, seq_len + 1);
         END_INVALID: begin
            do
               b = $urandom_range(255);
            while (base_code(b) != 8'd0 || is_blank(b) || b == CHAR_GT);
            send_record(1, $urandom_range(seq_len - 1));
            send_word(OP_TEXT, b);
         end
         END_NAME_SIZE: begin
            send_word(OP_TEXT, CHAR_GT);
            for (int i = 0; i < MAX_NAME_LENGTH + 3; i++)
               send_word(OP_TEXT, random_name_byte());
         end
         default: begin
            write_expected(13'(records_open + 13'd1));
            send_word(OP_TEXT, CHAR_GT);
            send_word(OP_TEXT, random_name_byte());
            send_word(OP_EOF, $urandom_range(255));
         end
      endcase
      wait_idle();
   endtask

   // after the end every word answers with the final status
   task automatic test_sticky_tail();
      send_idle_pct = 36;
      recv_idle_pct = 65;
      for (int i = 0; i < 30; i++)
         send_word(logic'($urandom_range(1)), $urandom_range(255));
      wait_idle();
   endtask

   initial begin
      ending = ending_type'($urandom_range(7));
      // the long name case carries most of the word budget by itself
      if (ending == END_NAME_SIZE)
         record_words = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_preamble();
      test_first_record();
      test_random_records(36, 65, record_words);
      test_random_records(65, 36, record_words);
      test_random_records(0, 0, record_words);
      test_termination();
      test_sticky_tail();
      repeat (10) @(posedge clock);
      if (words_checked != words_sent)
         report_mismatch("result count", 32'(words_checked), 32'(words_sent));
      $display("sent %0d words over %0d records of length %0d, checked %0d results",
               words_sent, records_open, seq_len, words_checked);
      $display("terminal case %s, %0d mismatches", ending.name(), mismatch_count);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
